/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the histogram equalizer.
// No dependencies; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define GHEQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gheq: property failed");

// Clocked check that also runs during reset.
`define GHEQ_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gheq: reset-time property failed");

`endif

/* rtl/gheq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, request structs and helper functions of the histogram equalizer.
// No dependencies.
package gheq_pkg;

    localparam int GREY_LEVELS = 256;
    localparam int MAX_SIDE    = 4096;

    localparam int PIX_W     = 8;
    localparam int OUT_W     = 8;
    localparam int DIM_W     = 13;
    localparam int BIN_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int LEVEL_W = $clog2(GREY_LEVELS);
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int N_W     = 2 * SIDE_W;
    localparam int DEN_W   = N_W + 1;
    localparam int CDF_W   = BIN_W + LEVEL_W;
    localparam int P_W     = CDF_W + LEVEL_W + 1;
    localparam int NUM_W   = ((P_W > N_W) ? P_W : N_W) + 1;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(GREY_LEVELS - 1);
    localparam logic [BIN_W-1:0]   BIN_MAX   = '1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(480);

    // Histogram port: count update and sweep read never issue together.
    typedef struct packed {
        logic               cnt_en;
        logic               clr;
        logic [LEVEL_W-1:0] cnt_idx;
        logic               rd_en;
        logic [LEVEL_W-1:0] rd_idx;
    } hist_req_t;

    typedef struct packed {
        logic               we;
        logic [LEVEL_W-1:0] waddr;
        logic [LEVEL_W-1:0] wdata;
        logic               re;
        logic [LEVEL_W-1:0] raddr;
    } lut_req_t;

    // Zero reads as one, oversize reads as the largest side.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = SIDE_W'(1);
            end
            else if (int'(v) > MAX_SIDE)
            begin
                r = SIDE_W'(MAX_SIDE);
            end
            else
            begin
                r = SIDE_W'(v);
            end
            return r;
        end
    endfunction

    function automatic logic [LEVEL_W-1:0] level_index(input logic [PIX_W-1:0] p);
        logic [LEVEL_W-1:0] r;
        begin
            if (int'(p) >= GREY_LEVELS)
            begin
                r = TOP_LEVEL;
            end
            else
            begin
                r = LEVEL_W'(p);
            end
            return r;
        end
    endfunction

endpackage

/* rtl/gheq_bin_mem.sv */
`timescale 1ns / 1ps
// Histogram bin RAM with per-bin valid bits and a read-increment-write count path.
// Depends on gheq_pkg.
module gheq_bin_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gheq_pkg::hist_req_t        req,
    output logic [gheq_pkg::BIN_W-1:0] bin_value
);

    logic [gheq_pkg::BIN_W-1:0]       bin_ram [gheq_pkg::GREY_LEVELS];
    logic [gheq_pkg::GREY_LEVELS-1:0] bin_valid_reg;
    logic [gheq_pkg::GREY_LEVELS-1:0] bin_valid_next;

    logic [gheq_pkg::BIN_W-1:0]   rdata_reg;
    logic                         vbit_reg;
    logic                         s1_valid_reg;
    logic [gheq_pkg::LEVEL_W-1:0] s1_idx_reg;
    logic                         fwd_hit_reg;
    logic [gheq_pkg::BIN_W-1:0]   fwd_data_reg;

    logic [gheq_pkg::LEVEL_W-1:0] addr;
    logic                         rd_any;
    logic [gheq_pkg::BIN_W-1:0]   old_value;
    logic [gheq_pkg::BIN_W-1:0]   inc_value;

    assign addr   = req.cnt_en ? req.cnt_idx : req.rd_idx;
    assign rd_any = req.cnt_en | req.rd_en;

    // A bin written at the same edge as its read comes from the forward register.
    assign old_value = fwd_hit_reg ? fwd_data_reg : (vbit_reg ? rdata_reg : '0);
    assign inc_value = (old_value == gheq_pkg::BIN_MAX) ? old_value
                                                         : old_value + gheq_pkg::BIN_W'(1);
    assign bin_value = old_value;

    always_comb
    begin
        bin_valid_next = req.clr ? '0 : bin_valid_reg;
        if (s1_valid_reg)
        begin
            bin_valid_next[s1_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_any)
        begin
            rdata_reg <= bin_ram[addr];
        end
        if (s1_valid_reg)
        begin
            bin_ram[s1_idx_reg] <= inc_value;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= req.cnt_idx;
        fwd_data_reg <= inc_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            vbit_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            bin_valid_reg <= bin_valid_next;
            vbit_reg      <= req.clr ? 1'b0 : bin_valid_reg[addr];
            s1_valid_reg  <= req.cnt_en;
            fwd_hit_reg   <= req.cnt_en && s1_valid_reg && (s1_idx_reg == req.cnt_idx);
        end
    end

endmodule

/* rtl/gheq_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, result capped at the top grey level.
// Depends on gheq_pkg. The divisor must stay stable until done.
module gheq_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gheq_pkg::NUM_W-1:0]   num,
    input  logic [gheq_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [gheq_pkg::LEVEL_W-1:0] quot
);

    localparam int LW    = gheq_pkg::LEVEL_W;
    localparam int DW    = gheq_pkg::DEN_W;
    localparam int NW    = gheq_pkg::NUM_W;
    localparam int CNT_W = $clog2(LW + 1);
    localparam int CMP_W = (NW > DW + LW) ? NW : DW + LW;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [LW-1:0]    lo_reg;
    logic [LW-1:0]    q_reg;
    logic [LW-1:0]    quot_reg;

    logic             cap;
    logic [NW+DW-1:0] head_wide;
    logic [DW:0]      sh;
    logic             ge;
    logic [DW-1:0]    rem_step;
    logic [LW-1:0]    q_step;

    // Quotient of 2^LW or more is past the top level anyway.
    assign cap       = CMP_W'(num) >= (CMP_W'(den) << LW);
    assign head_wide = (NW + DW)'(num >> LW);

    assign sh       = {rem_reg, lo_reg[LW-1]};
    assign ge       = sh >= {1'b0, den};
    assign rem_step = ge ? DW'(sh - {1'b0, den}) : sh[DW-1:0];
    assign q_step   = LW'({q_reg, ge});

    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= head_wide[DW-1:0];
            lo_reg  <= num[LW-1:0];
            q_reg   <= '0;
            if (cap)
            begin
                quot_reg <= gheq_pkg::TOP_LEVEL;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            lo_reg  <= lo_reg << 1;
            q_reg   <= q_step;
            if (cnt_reg == LAST_STEP)
            begin
                quot_reg <= (q_step > gheq_pkg::TOP_LEVEL) ? gheq_pkg::TOP_LEVEL : q_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= !cap;
                done_reg <= cap;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/gheq_lut.sv */
`timescale 1ns / 1ps
// Mapping table RAM: one write and one registered read per cycle.
// Depends on gheq_pkg.
module gheq_lut (
    input  logic                         clk,
    input  gheq_pkg::lut_req_t           req,
    output logic [gheq_pkg::LEVEL_W-1:0] rdata
);

    logic [gheq_pkg::LEVEL_W-1:0] lut_ram [gheq_pkg::GREY_LEVELS];
    logic [gheq_pkg::LEVEL_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            lut_ram[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= lut_ram[req.raddr];
        end
    end

endmodule

/* rtl/global_histogram_equalizer.sv */
`timescale 1ns / 1ps
// Global histogram equalizer for one 8-bit grey channel; top level.
// Depends on gheq_pkg, gheq_bin_mem, gheq_div and gheq_lut.
// Input channel (in_valid/in_ready, command, pixel_value): a count beat adds the
// pixel to its histogram bin and returns nothing; a map beat returns one
// mapped_value beat on the output channel (out_valid/out_ready).
// Count beats go at one per cycle while in_ready is high; the bin RAM does
// read-increment-write in two stages, forwarding between back-to-back same-bin beats.
// Map beats go at one per cycle while in_ready is high; each passes the table RAM
// read, then the output queue, before its out_valid.
// The first map beat after counting builds the table: per grey level one bin
// read, accumulate, multiply, add and a one-bit-per-cycle divide; in_ready is
// low meanwhile. The first count beat after mapping clears the histogram.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always ready;
// write only while the block is idle.
// Reset clears the histogram, selects counting and loads 640 x 480.
// in_ready drops once queued and in-flight result beats reach the two queue slots.
module global_histogram_equalizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [gheq_pkg::PIX_W-1:0]     pixel_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gheq_pkg::OUT_W-1:0]     mapped_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gheq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gheq_pkg::DIM_W-1:0]     cfg_data
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_RUN     = 4'd0;
    localparam logic [STATE_W-1:0] S_START   = 4'd1;
    localparam logic [STATE_W-1:0] S_RD      = 4'd2;
    localparam logic [STATE_W-1:0] S_ACC     = 4'd3;
    localparam logic [STATE_W-1:0] S_MUL     = 4'd4;
    localparam logic [STATE_W-1:0] S_ADD     = 4'd5;
    localparam logic [STATE_W-1:0] S_DIVGO   = 4'd6;
    localparam logic [STATE_W-1:0] S_DIVWAIT = 4'd7;
    localparam logic [STATE_W-1:0] S_MAPRD   = 4'd8;

    localparam int LW = gheq_pkg::LEVEL_W;
    localparam logic [LW:0] TWICE_TOP = {gheq_pkg::TOP_LEVEL, 1'b0};

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;

    logic [gheq_pkg::DIM_W-1:0] width_reg;
    logic [gheq_pkg::DIM_W-1:0] height_reg;
    logic                       in_map_phase_reg;

    logic [LW-1:0]              k_reg;
    logic [LW-1:0]              pend_idx_reg;
    logic [gheq_pkg::CDF_W-1:0] cdf_reg;
    logic [gheq_pkg::N_W-1:0]   n_reg;
    logic [gheq_pkg::P_W-1:0]   prod_reg;
    logic [gheq_pkg::NUM_W-1:0] num_reg;

    logic                       rd_pend_reg;
    logic [1:0]                 q_cnt_reg;
    logic [1:0]                 q_cnt_next;
    logic [gheq_pkg::OUT_W-1:0] head_reg;
    logic [gheq_pkg::OUT_W-1:0] head_next;
    logic [gheq_pkg::OUT_W-1:0] tail_reg;
    logic [gheq_pkg::OUT_W-1:0] tail_next;

    logic [LW-1:0]              in_idx;
    logic [1:0]                 occ;
    logic                       pop;
    logic                       slot_ok;
    logic                       accept;
    logic                       cnt_acc;
    logic                       map_acc;
    logic [gheq_pkg::N_W-1:0]   n_next;
    logic [gheq_pkg::OUT_W-1:0] push_data;

    gheq_pkg::hist_req_t          hist_req;
    gheq_pkg::lut_req_t           lut_req;
    logic [gheq_pkg::BIN_W-1:0]   bin_value;
    logic [LW-1:0]                lut_rdata;
    logic                         div_start;
    logic                         div_done;
    logic [LW-1:0]                div_quot;
    logic [gheq_pkg::DEN_W-1:0]   den;

    assign in_idx = gheq_pkg::level_index(pixel_value);

    // Count pending table reads against the two queue slots.
    assign occ     = {1'b0, rd_pend_reg} + q_cnt_reg;
    assign pop     = out_valid && out_ready;
    assign slot_ok = (occ - {1'b0, pop}) < 2'd2;

    assign in_ready  = (state_reg == S_RUN) && slot_ok;
    assign accept    = in_valid && in_ready;
    assign cnt_acc   = accept && (command == gheq_pkg::CMD_COUNT);
    assign map_acc   = accept && (command == gheq_pkg::CMD_MAP);
    assign cfg_ready = 1'b1;

    assign n_next = gheq_pkg::N_W'(gheq_pkg::clamp_side(width_reg))
                  * gheq_pkg::N_W'(gheq_pkg::clamp_side(height_reg));
    assign den    = {n_reg, 1'b0};

    always_comb
    begin
        hist_req.cnt_en  = cnt_acc;
        hist_req.clr     = cnt_acc && in_map_phase_reg;
        hist_req.cnt_idx = in_idx;
        hist_req.rd_en   = (state_reg == S_RD);
        hist_req.rd_idx  = k_reg;

        lut_req.we    = (state_reg == S_DIVWAIT) && div_done;
        lut_req.waddr = k_reg;
        lut_req.wdata = div_quot;
        lut_req.re    = (map_acc && in_map_phase_reg) || (state_reg == S_MAPRD);
        lut_req.raddr = (state_reg == S_MAPRD) ? pend_idx_reg : in_idx;
    end

    assign div_start = (state_reg == S_DIVGO);

    gheq_bin_mem u_bin_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (hist_req),
        .bin_value (bin_value)
    );

    gheq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    gheq_lut u_lut (
        .clk   (clk),
        .req   (lut_req),
        .rdata (lut_rdata)
    );

    always_comb
    begin
        case (state_reg)
            S_RUN:
            begin
                state_next = (map_acc && !in_map_phase_reg) ? S_START : S_RUN;
            end
            S_START:   state_next = S_RD;
            S_RD:      state_next = S_ACC;
            S_ACC:     state_next = S_MUL;
            S_MUL:     state_next = S_ADD;
            S_ADD:     state_next = S_DIVGO;
            S_DIVGO:   state_next = S_DIVWAIT;
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = (k_reg == gheq_pkg::TOP_LEVEL) ? S_MAPRD : S_RD;
                end
                else
                begin
                    state_next = S_DIVWAIT;
                end
            end
            S_MAPRD:   state_next = S_RUN;
            default:   state_next = S_RUN;
        endcase
    end

    // Two-entry output queue: head drives the port, tail absorbs a stall.
    assign push_data = gheq_pkg::OUT_W'(lut_rdata);

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case (q_cnt_reg)
            2'd0:
            begin
                if (rd_pend_reg)
                begin
                    head_next  = push_data;
                    q_cnt_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pop && rd_pend_reg)
                begin
                    head_next = push_data;
                end
                else if (rd_pend_reg)
                begin
                    tail_next  = push_data;
                    q_cnt_next = 2'd2;
                end
                else if (pop)
                begin
                    q_cnt_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    if (rd_pend_reg)
                    begin
                        tail_next = push_data;
                    end
                    else
                    begin
                        q_cnt_next = 2'd1;
                    end
                end
            end
            default:
            begin
                q_cnt_next = 2'd0;
            end
        endcase
    end

    assign out_valid    = (q_cnt_reg != 2'd0);
    assign mapped_value = head_reg;

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (map_acc)
        begin
            pend_idx_reg <= in_idx;
        end
        case (state_reg)
            S_START:
            begin
                k_reg   <= '0;
                cdf_reg <= '0;
                n_reg   <= n_next;
            end
            S_ACC:
            begin
                cdf_reg <= cdf_reg + gheq_pkg::CDF_W'(bin_value);
            end
            S_MUL:
            begin
                prod_reg <= cdf_reg * TWICE_TOP;
            end
            S_ADD:
            begin
                num_reg <= gheq_pkg::NUM_W'(prod_reg) + gheq_pkg::NUM_W'(n_reg);
            end
            S_DIVWAIT:
            begin
                if (div_done && (k_reg != gheq_pkg::TOP_LEVEL))
                begin
                    k_reg <= k_reg + LW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_RUN;
            width_reg        <= gheq_pkg::RST_IMAGE_WIDTH;
            height_reg       <= gheq_pkg::RST_IMAGE_HEIGHT;
            in_map_phase_reg <= 1'b0;
            rd_pend_reg      <= 1'b0;
            q_cnt_reg        <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= lut_req.re;
            q_cnt_reg   <= q_cnt_next;
            if (cnt_acc)
            begin
                in_map_phase_reg <= 1'b0;
            end
            else if (map_acc)
            begin
                in_map_phase_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gheq_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    gheq_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/gheq_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the histogram equalizer, bound to the top level.
// Depends on gheq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gheq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       command,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [gheq_pkg::OUT_W-1:0] mapped_value
);

    // Hold a stalled result beat.
    `GHEQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
    `GHEQ_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(mapped_value))

    // The output queue is empty while in reset.
    `GHEQ_ASSERT_RST(a_rst_quiet, !rst_n |-> !out_valid)

    // A map beat right after a count beat starts the table build and drops ready.
    `GHEQ_ASSERT(a_build_stall, in_valid && in_ready && (command == gheq_pkg::CMD_MAP) && $past(in_valid && in_ready && (command == gheq_pkg::CMD_COUNT)) |=> !in_ready)

endmodule

bind global_histogram_equalizer gheq_checker u_gheq_checker (.*);
